>>> hw/rtl/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// Shared constants for the chunk residency manager.
// ----------------------------------------------------------------------------
package crm_pkg;
    localparam int MAX_CHUNKS_DEF = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int POS_BITS       = 24;
    localparam int SIZE_BITS      = 9;
    localparam int CURRENT_RESET  = -100;
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
endpackage

>>> hw/rtl/crm_floor_div.sv
// ----------------------------------------------------------------------------
// crm_floor_div
// Restoring divider: signed position floor-divided by an unsigned size.
// ----------------------------------------------------------------------------
module crm_floor_div #(
    parameter int COORD_BITS = crm_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [crm_pkg::POS_BITS-1:0] pos,
    input  logic [crm_pkg::SIZE_BITS-1:0]  size,
    output logic                            done,
    output logic [COORD_BITS-1:0]          quot
);
    localparam int PB = crm_pkg::POS_BITS;
    localparam int SB = crm_pkg::SIZE_BITS;
    logic [PB-1:0]   mag_reg, q_reg;
    logic [SB:0]     rem_reg;
    logic [SB-1:0]   div_reg;
    logic            neg_reg, busy_reg, done_reg;
    logic [4:0]      cnt_reg;
    logic [SB:0]     trial;
    logic [SB:0]     sh;
    logic [PB:0]     qn;

    assign sh    = {rem_reg[SB-1:0], mag_reg[PB-1]};
    assign trial = sh - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                neg_reg  <= pos[PB-1];
                mag_reg  <= pos[PB-1] ? PB'(-pos) : pos;
                div_reg  <= (size == '0) ? SB'(1) : size;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                mag_reg <= {mag_reg[PB-2:0], 1'b0};
                if (!trial[SB]) begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[PB-2:0], 1'b1};
                end else begin
                    rem_reg <= sh;
                    q_reg   <= {q_reg[PB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(PB-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // negative: -(q) minus one when the remainder is nonzero
    always_comb begin
        if (neg_reg)
            qn = (rem_reg != '0) ? ~{1'b0, q_reg} : -{1'b0, q_reg};
        else
            qn = {1'b0, q_reg};
    end
    assign done = done_reg;
    assign quot = COORD_BITS'($signed(qn));
endmodule

>>> hw/rtl/chunk_residency_manager_core.sv
// ----------------------------------------------------------------------------
// chunk_residency_manager_core
// Maps a viewer position to a chunk and keeps a table of resident chunks.
// ----------------------------------------------------------------------------
// Usage: present pos_x/y/z on the s_ channel. The position is floor-divided
// per axis by the chunk size through one shared serial divider. If the
// chunk is unchanged one result (changed = 0, last = 1) follows. Otherwise
// nine neighbour results follow, NW to SE, with last on the ninth. Each
// neighbour scans the slot table once to look up (one slot a cycle), and
// when the table overflows scans it again for the furthest entry.
// s_ready is high only while the block is idle. Each result sits in an
// output register until the m_ transfer; the sequencer holds meanwhile, so
// a receiver stall only stretches the item. Reset clears the valid bits,
// sets the current chunk to -100 on each axis and the sizes to 16.
// Chunk sizes are written through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module chunk_residency_manager_core #(
    parameter int MAX_CHUNKS = crm_pkg::MAX_CHUNKS_DEF,
    parameter int COORD_BITS = crm_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [crm_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [crm_pkg::POS_BITS-1:0] s_pos_x,
    input  logic signed [crm_pkg::POS_BITS-1:0] s_pos_y,
    input  logic signed [crm_pkg::POS_BITS-1:0] s_pos_z,
    output logic m_valid,
    input  logic m_ready,
    output logic m_changed,
    output logic signed [crm_pkg::POS_BITS-1:0] m_chunk_x,
    output logic signed [crm_pkg::POS_BITS-1:0] m_chunk_y,
    output logic signed [crm_pkg::POS_BITS-1:0] m_chunk_z,
    output logic m_added,
    output logic m_evicted_valid,
    output logic signed [crm_pkg::POS_BITS-1:0] m_evicted_x,
    output logic signed [crm_pkg::POS_BITS-1:0] m_evicted_y,
    output logic signed [crm_pkg::POS_BITS-1:0] m_evicted_z,
    output logic m_last
);
    localparam int CB = COORD_BITS;
    localparam int PB = crm_pkg::POS_BITS;
    localparam int SB = crm_pkg::SIZE_BITS;
    localparam int NS = MAX_CHUNKS + 1;
    localparam int IW = $clog2(NS + 1);
    localparam int XW = $clog2(NS);
    localparam int DW = CB + 3;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_DIV = 4'd1, ST_DWAIT = 4'd2,
                           ST_CMP = 4'd3, ST_LOOK = 4'd4, ST_INS = 4'd5,
                           ST_EVS = 4'd6, ST_EVD = 4'd7, ST_OUT = 4'd8;

    logic [3:0] state_reg;
    logic [1:0] axis_reg;
    logic [CB-1:0] cx_reg, cy_reg, cz_reg, cur_x_reg, cur_y_reg, cur_z_reg;
    logic [CB-1:0] nx_reg, nz_reg;
    logic [SB-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic signed [PB-1:0] px_reg, py_reg, pz_reg;
    logic [CB-1:0] slot_x [NS];
    logic [CB-1:0] slot_y [NS];
    logic [CB-1:0] slot_z [NS];
    logic [NS-1:0] valid_reg;
    logic [XW-1:0] idx_reg, free_reg, best_reg;
    logic found_reg, free_ok_reg, best_ok_reg;
    logic [IW-1:0] count_reg;
    logic [DW-1:0] bestd_reg;
    logic [1:0] dx_reg, dz_reg;   // 0,1,2 -> -1,0,+1
    logic [XW-1:0] idx;

    logic div_start, div_done;
    logic signed [PB-1:0] div_pos;
    logic [SB-1:0] div_size;
    logic [CB-1:0] div_q;

    crm_floor_div #(.COORD_BITS(CB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .pos(div_pos),
        .size(div_size), .done(div_done), .quot(div_q)
    );

    assign idx = idx_reg;
    assign div_start = (state_reg == ST_DIV);
    always_comb begin
        case (axis_reg)
            2'd0:    begin div_pos = px_reg; div_size = size_x_reg; end
            2'd1:    begin div_pos = py_reg; div_size = size_y_reg; end
            default: begin div_pos = pz_reg; div_size = size_z_reg; end
        endcase
    end

    // distance unit: one slot against the current chunk
    logic signed [CB:0] ddx, ddy, ddz;
    logic [DW-1:0] slot_dist;
    assign ddx = $signed({slot_x[idx][CB-1], slot_x[idx]}) - $signed({cx_reg[CB-1], cx_reg});
    assign ddy = $signed({slot_y[idx][CB-1], slot_y[idx]}) - $signed({cy_reg[CB-1], cy_reg});
    assign ddz = $signed({slot_z[idx][CB-1], slot_z[idx]}) - $signed({cz_reg[CB-1], cz_reg});
    assign slot_dist = DW'(ddx[CB] ? -ddx : ddx) + DW'(ddy[CB] ? -ddy : ddy)
                     + DW'(ddz[CB] ? -ddz : ddz);

    logic hit;
    assign hit = valid_reg[idx] && slot_x[idx] == nx_reg && slot_y[idx] == cy_reg
                 && slot_z[idx] == nz_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            m_valid    <= 1'b0;
            size_x_reg <= SB'(16);
            size_y_reg <= SB'(16);
            size_z_reg <= SB'(16);
            cur_x_reg  <= CB'(crm_pkg::CURRENT_RESET);
            cur_y_reg  <= CB'(crm_pkg::CURRENT_RESET);
            cur_z_reg  <= CB'(crm_pkg::CURRENT_RESET);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    crm_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                    crm_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                    crm_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    px_reg <= s_pos_x; py_reg <= s_pos_y; pz_reg <= s_pos_z;
                    axis_reg <= 2'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: state_reg <= ST_DWAIT;
                ST_DWAIT: if (div_done) begin
                    case (axis_reg)
                        2'd0:    cx_reg <= div_q;
                        2'd1:    cy_reg <= div_q;
                        default: cz_reg <= div_q;
                    endcase
                    if (axis_reg == 2'd2) state_reg <= ST_CMP;
                    else begin
                        axis_reg <= axis_reg + 2'd1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_CMP: begin
                    if (cx_reg == cur_x_reg && cy_reg == cur_y_reg && cz_reg == cur_z_reg) begin
                        // unchanged chunk: single result
                        m_changed <= 1'b0; m_added <= 1'b0; m_evicted_valid <= 1'b0;
                        m_chunk_x <= PB'($signed(cx_reg));
                        m_chunk_y <= PB'($signed(cy_reg));
                        m_chunk_z <= PB'($signed(cz_reg));
                        m_evicted_x <= '0; m_evicted_y <= '0; m_evicted_z <= '0;
                        m_last <= 1'b1;
                        m_valid <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        cur_x_reg <= cx_reg; cur_y_reg <= cy_reg; cur_z_reg <= cz_reg;
                        dx_reg <= 2'd0; dz_reg <= 2'd0;
                        nx_reg <= cx_reg - CB'(1); nz_reg <= cz_reg - CB'(1);
                        idx_reg <= '0; found_reg <= 1'b0; free_ok_reg <= 1'b0;
                        count_reg <= '0;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    // walk slots: count, match, first free
                    if (valid_reg[idx]) count_reg <= count_reg + IW'(1);
                    if (hit) found_reg <= 1'b1;
                    if (!valid_reg[idx] && !free_ok_reg) begin
                        free_ok_reg <= 1'b1; free_reg <= idx;
                    end
                    if (idx_reg == XW'(NS-1)) state_reg <= ST_INS;
                    else idx_reg <= idx_reg + XW'(1);
                end
                ST_INS: begin
                    m_changed <= 1'b1;
                    m_chunk_x <= PB'($signed(nx_reg));
                    m_chunk_y <= PB'($signed(cy_reg));
                    m_chunk_z <= PB'($signed(nz_reg));
                    m_evicted_valid <= 1'b0;
                    m_evicted_x <= '0; m_evicted_y <= '0; m_evicted_z <= '0;
                    m_last <= (dx_reg == 2'd2) && (dz_reg == 2'd2);
                    if (!found_reg && free_ok_reg) begin
                        slot_x[free_reg] <= nx_reg;
                        slot_y[free_reg] <= cy_reg;
                        slot_z[free_reg] <= nz_reg;
                        valid_reg[free_reg] <= 1'b1;
                        m_added <= 1'b1;
                        if (count_reg + IW'(1) > IW'(MAX_CHUNKS)) begin
                            idx_reg <= '0; best_ok_reg <= 1'b0; bestd_reg <= '0;
                            state_reg <= ST_EVS;
                        end else begin
                            m_valid <= 1'b1; state_reg <= ST_OUT;
                        end
                    end else begin
                        m_added <= 1'b0;
                        m_valid <= 1'b1; state_reg <= ST_OUT;
                    end
                end
                ST_EVS: begin
                    // furthest scan, strict > keeps the lowest slot on ties
                    if (valid_reg[idx] && (!best_ok_reg || slot_dist > bestd_reg)) begin
                        best_ok_reg <= 1'b1; best_reg <= idx; bestd_reg <= slot_dist;
                    end
                    if (idx_reg == XW'(NS-1)) state_reg <= ST_EVD;
                    else idx_reg <= idx_reg + XW'(1);
                end
                ST_EVD: begin
                    if (best_ok_reg) begin
                        m_evicted_valid <= 1'b1;
                        m_evicted_x <= PB'($signed(slot_x[best_reg]));
                        m_evicted_y <= PB'($signed(slot_y[best_reg]));
                        m_evicted_z <= PB'($signed(slot_z[best_reg]));
                        valid_reg[best_reg] <= 1'b0;
                    end
                    m_valid <= 1'b1; state_reg <= ST_OUT;
                end
                ST_OUT: if (m_valid && m_ready) begin
                    if (m_last) state_reg <= ST_IDLE;
                    else begin
                        // advance to next neighbour
                        if (dx_reg == 2'd2) begin
                            dx_reg <= 2'd0; dz_reg <= dz_reg + 2'd1;
                            nx_reg <= cx_reg - CB'(1); nz_reg <= nz_reg + CB'(1);
                        end else begin
                            dx_reg <= dx_reg + 2'd1; nx_reg <= nx_reg + CB'(1);
                        end
                        idx_reg <= '0; found_reg <= 1'b0; free_ok_reg <= 1'b0;
                        count_reg <= '0;
                        state_reg <= ST_LOOK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
